/* hdl/srbp_pkg.sv */
package srbp_pkg;

	localparam int WORD_BITS = 32;
	localparam int OFF_W     = 5;
	localparam int FIELD_W   = 16;
	localparam int WIDTH_W   = 5;
	localparam int WIN_W     = 2 * WORD_BITS;

	typedef enum logic [1:0] {
		FUNC_APPEND  = 2'd0,
		FUNC_EXTRACT = 2'd1,
		FUNC_SEAL    = 2'd2,
		FUNC_CLEAR   = 2'd3
	} func_t;

	typedef struct packed {
		logic [FIELD_W-1:0] field_bits;
		logic [WIDTH_W-1:0] field_width;
		logic               out_of_range;
	} result_t;

	// Smallest w in 1..16 with 2^w >= count: bit length of count - 1.
	function automatic logic [WIDTH_W-1:0] width_of(input logic [FIELD_W-1:0] count);
		logic [FIELD_W-1:0] top;
		logic [WIDTH_W-1:0] w;
		top = count - FIELD_W'(1);
		w   = WIDTH_W'(1);
		if (count > FIELD_W'(2)) begin
			for (int i = 0; i < FIELD_W; i++) begin
				if (top[i]) begin
					w = WIDTH_W'(i + 1);
				end
			end
		end
		return w;
	endfunction

endpackage

/* hdl/srbp_core.sv */
module srbp_core #(
	parameter int MAX_BITS = 256,
	localparam int CW = $clog2(MAX_BITS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  srbp_pkg::func_t               func,
	input  logic [srbp_pkg::FIELD_W-1:0]  nix_value,
	input  logic [srbp_pkg::FIELD_W-1:0]  neighbor_count,
	output srbp_pkg::result_t             result,
	output logic [CW-1:0]                 remaining
);

	localparam int WORDS = (MAX_BITS + srbp_pkg::WORD_BITS - 1) / srbp_pkg::WORD_BITS;
	localparam int OW    = srbp_pkg::OFF_W;
	localparam int CWW   = CW - OW;
	localparam int WB    = srbp_pkg::WORD_BITS;
	localparam int FW    = srbp_pkg::FIELD_W;
	localparam int WW    = srbp_pkg::WIDTH_W;
	localparam int NW    = srbp_pkg::WIN_W;

	logic [WB-1:0]  store_q [WORDS];
	logic [WB-1:0]  store_d [WORDS];
	logic [CW-1:0]  cursor_q, cursor_d;
	logic [CW-1:0]  length_q, length_d;

	logic [WW-1:0]  w;
	logic [CW:0]    end_pos;
	logic [CW+1:0]  round_up;
	logic [CW+1:0]  rounded;
	logic [CWW-1:0] cur_word;
	logic [CWW:0]   nxt_word;
	logic [OW-1:0]  cur_off;
	logic [WB-1:0]  win_hi, win_lo;
	logic [NW-1:0]  win_shl;
	logic [FW-1:0]  ext_bits;
	logic [FW-1:0]  val_mask;
	logic [NW-1:0]  ins_val, ins_mask;
	logic [WB-1:0]  new_hi, new_lo;
	logic           app_err, ext_err;
	logic           do_write;

	assign w        = srbp_pkg::width_of(neighbor_count);
	assign end_pos  = {1'b0, cursor_q} + (CW+1)'(w);
	assign cur_word = cursor_q[CW-1:OW];
	assign nxt_word = {1'b0, cur_word} + (CWW+1)'(1);
	assign cur_off  = cursor_q[OW-1:0];
	assign app_err  = end_pos > (CW+1)'(MAX_BITS);
	assign ext_err  = end_pos > {1'b0, length_q};

	// Round the new cursor up to a whole word, never beyond capacity.
	assign round_up = {1'b0, end_pos} + (CW+2)'(WB - 1);
	always_comb begin
		rounded = {round_up[CW+1:OW], OW'(0)};
		if (rounded > (CW+2)'(MAX_BITS)) begin
			rounded = (CW+2)'(MAX_BITS);
		end
	end

	// Gather the two words under the cursor; a word past the store reads zero.
	always_comb begin
		win_hi = '0;
		win_lo = '0;
		for (int k = 0; k < WORDS; k++) begin
			if (cur_word == CWW'(k)) begin
				win_hi = win_hi | store_q[k];
			end
			if (nxt_word == (CWW+1)'(k)) begin
				win_lo = win_lo | store_q[k];
			end
		end
	end

	assign win_shl  = {win_hi, win_lo} << cur_off;
	assign ext_bits = win_shl[NW-1:NW-FW] >> (WW'(FW) - w);

	assign val_mask = {FW{1'b1}} >> (WW'(FW) - w);
	assign ins_val  = ({nix_value & val_mask, (NW-FW)'(0)} << (WW'(FW) - w)) >> cur_off;
	assign ins_mask = ({val_mask, (NW-FW)'(0)} << (WW'(FW) - w)) >> cur_off;
	assign new_hi   = (win_hi & ~ins_mask[NW-1:WB]) | ins_val[NW-1:WB];
	assign new_lo   = (win_lo & ~ins_mask[WB-1:0]) | ins_val[WB-1:0];

	assign do_write = (func == srbp_pkg::FUNC_APPEND) && !app_err;

	always_comb begin
		for (int k = 0; k < WORDS; k++) begin
			store_d[k] = store_q[k];
			if (func == srbp_pkg::FUNC_CLEAR) begin
				store_d[k] = '0;
			end else if (do_write && cur_word == CWW'(k)) begin
				store_d[k] = new_hi;
			end else if (do_write && nxt_word == (CWW+1)'(k)) begin
				store_d[k] = new_lo;
			end
		end
	end

	always_comb begin
		cursor_d            = cursor_q;
		length_d            = length_q;
		result.field_bits   = '0;
		result.field_width  = w;
		result.out_of_range = 1'b0;
		unique case (func)
			srbp_pkg::FUNC_APPEND: begin
				if (app_err) begin
					result.out_of_range = 1'b1;
				end else begin
					cursor_d = end_pos[CW-1:0];
					if (rounded > (CW+2)'(length_q)) begin
						length_d = rounded[CW-1:0];
					end
				end
			end
			srbp_pkg::FUNC_EXTRACT: begin
				if (ext_err) begin
					result.out_of_range = 1'b1;
				end else begin
					cursor_d          = end_pos[CW-1:0];
					result.field_bits = ext_bits;
				end
			end
			srbp_pkg::FUNC_SEAL: begin
				length_d = cursor_q;
				cursor_d = '0;
			end
			srbp_pkg::FUNC_CLEAR: begin
				length_d = CW'(WB);
				cursor_d = '0;
			end
		endcase
		remaining = (length_d >= cursor_d) ? (length_d - cursor_d) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			length_q <= CW'(WB);
			for (int k = 0; k < WORDS; k++) begin
				store_q[k] <= '0;
			end
		end else if (advance) begin
			cursor_q <= cursor_d;
			length_q <= length_d;
			for (int k = 0; k < WORDS; k++) begin
				store_q[k] <= store_d[k];
			end
		end
	end

endmodule

/* hdl/srbp_out_reg.sv */
module srbp_out_reg #(
	parameter int CW = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  srbp_pkg::result_t             result,
	input  logic [CW-1:0]                 remaining,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [srbp_pkg::FIELD_W-1:0]  field_bits,
	output logic [srbp_pkg::WIDTH_W-1:0]  field_width,
	output logic                          out_of_range,
	output logic [CW-1:0]                 bits_remaining
);

	logic              valid_q;
	srbp_pkg::result_t result_q;
	logic [CW-1:0]     remaining_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q    <= result;
			remaining_q <= remaining;
		end
	end

	assign result_valid   = valid_q;
	assign field_bits     = result_q.field_bits;
	assign field_width    = result_q.field_width;
	assign out_of_range   = result_q.out_of_range;
	assign bits_remaining = remaining_q;

endmodule

/* hdl/source_route_bit_packer_unit.sv */
// Each item passes from the input register to the result register, held there while the result register stalls.
// One item per cycle while result_stall does not hold it back; the bit store, cursor and length update
// in the same cycle the item moves from the input register to the result register.
// Reset: store cleared, cursor 0, length one word (32 bits), both stages empty.
module source_route_bit_packer_unit #(
	parameter int MAX_BITS = 256,
	localparam int CW = $clog2(MAX_BITS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    func,
	input  logic [srbp_pkg::FIELD_W-1:0]  nix_value,
	input  logic [srbp_pkg::FIELD_W-1:0]  neighbor_count,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [srbp_pkg::FIELD_W-1:0]  field_bits,
	output logic [srbp_pkg::WIDTH_W-1:0]  field_width,
	output logic                          out_of_range,
	output logic [CW-1:0]                 bits_remaining
);

	logic                          valid_s1;
	srbp_pkg::func_t               func_s1;
	logic [srbp_pkg::FIELD_W-1:0]  nix_value_s1;
	logic [srbp_pkg::FIELD_W-1:0]  neighbor_count_s1;
	logic                          accept;
	logic                          advance;
	srbp_pkg::result_t             result;
	logic [CW-1:0]                 remaining;

	// Advance when the result register is empty or being drained.
	assign advance    = valid_s1 && (!result_valid || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			func_s1  <= srbp_pkg::FUNC_APPEND;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			func_s1  <= srbp_pkg::func_t'(func);
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			nix_value_s1      <= nix_value;
			neighbor_count_s1 <= neighbor_count;
		end
	end

	srbp_core #(
		.MAX_BITS(MAX_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.func           (func_s1),
		.nix_value      (nix_value_s1),
		.neighbor_count (neighbor_count_s1),
		.result         (result),
		.remaining      (remaining)
	);

	srbp_out_reg #(
		.CW(CW)
	) u_out_reg (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (advance),
		.result         (result),
		.remaining      (remaining),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.field_bits     (field_bits),
		.field_width    (field_width),
		.out_of_range   (out_of_range),
		.bits_remaining (bits_remaining)
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid && result_stall))
		else $error("input stalled while a stage was free");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("advanced item did not reach the result register");

	a_remaining_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (bits_remaining <= CW'(MAX_BITS)))
		else $error("bits remaining exceeds capacity");

	a_error_zero_field: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && out_of_range) |-> (field_bits == '0 && field_width != '0))
		else $error("error result carries field data");

endmodule
